// ----- src/tsri_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsri_pkg
// Shared types and constants of the timestamped ring interpolator.
// ----------------------------------------------------------------------------
package tsri_pkg;

   localparam int TIME_W         = 48;
   localparam int ANGLE_W        = 32;
   localparam int DIFF_A_W       = ANGLE_W + 1;
   localparam int DIFF_T_W       = TIME_W + 1;
   localparam int HALF_W         = TIME_W / 2;
   localparam int PART_W         = ANGLE_W + HALF_W;
   localparam int PROD_W         = ANGLE_W + TIME_W;
   localparam int QUOT_W         = 40;
   localparam int SUM_W          = QUOT_W + 2;
   localparam int RING_DEPTH_DEF = 16;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic OP_STORE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
   localparam logic [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

   typedef struct packed {
      logic                      kind;
      logic [TIME_W-1:0]         timestamp;
      logic signed [ANGLE_W-1:0] angle;
   } req_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] result_angle;
      logic [TIME_W-1:0]         result_time;
      logic                      found;
   } rsp_type;

   typedef struct packed {
      logic               op;
      logic [TIME_W-1:0]  stamp;
      logic [ANGLE_W-1:0] angle;
   } cmd_type;

   typedef struct packed {
      logic               start;
      logic [TIME_W-1:0]  rem_init;
      logic [QUOT_W-1:0]  dividend;
      logic [TIME_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic [QUOT_W-1:0] quotient;
   } div_sts_type;

endpackage

// ----- src/tsri_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsri_front
// Input stage: takes request beats, decodes them into store or query commands
// and hands them to the command queue.
// ----------------------------------------------------------------------------
module tsri_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  tsri_pkg::req_type req_data,
   output logic              req_stall,
   input  logic              q_full,
   output logic              q_push,
   output tsri_pkg::cmd_type q_push_data
);
   import tsri_pkg::*;

   logic    hold_vld_ff, hold_vld_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;

   assign req_stall   = hold_vld_ff && q_full;
   assign accept      = req_valid && !req_stall;
   assign q_push      = hold_vld_ff && !q_full;
   assign q_push_data = cmd_ff;

   always_comb begin
      hold_vld_in = hold_vld_ff;
      cmd_in      = cmd_ff;
      if (q_push) begin
         hold_vld_in = 1'b0;
      end
      if (accept) begin
         hold_vld_in  = 1'b1;
         cmd_in.op    = req_data.kind ? OP_QUERY : OP_STORE;
         cmd_in.stamp = req_data.timestamp;
         // queries carry no angle
         cmd_in.angle = req_data.kind ? '0 : req_data.angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
      end else begin
         hold_vld_ff <= hold_vld_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

// ----- src/tsri_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsri_queue
// Short command queue between the input stage and the execution unit.
// ----------------------------------------------------------------------------
module tsri_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tsri_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output tsri_pkg::cmd_type pop_data
);
   import tsri_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == DEPTH_CNT);
   assign valid    = (count_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/tsri_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsri_divider
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the starting remainder is below the divisor.
// ----------------------------------------------------------------------------
module tsri_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  tsri_pkg::div_req_type div_req,
   output tsri_pkg::div_sts_type div_sts
);
   import tsri_pkg::*;

   localparam int STEP_W = $clog2(QUOT_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_W - 1);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [TIME_W-1:0] dsr_ff, dsr_in;
   logic [QUOT_W-1:0] dvd_ff, dvd_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [TIME_W:0]   trial;
   logic [TIME_W:0]   diff;
   logic              fits;

   assign trial = {rem_ff, dvd_ff[QUOT_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = !diff[TIME_W];

   assign div_sts.busy     = busy_ff;
   assign div_sts.quotient = quot_ff;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      dvd_in  = dvd_ff;
      quot_in = quot_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = div_req.rem_init;
         dsr_in  = div_req.divisor;
         dvd_in  = div_req.dividend;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
         dvd_in  = {dvd_ff[QUOT_W-2:0], 1'b0};
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      dvd_ff  <= dvd_in;
      quot_ff <= quot_in;
   end

endmodule

// ----- src/tsri_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsri_back
// Execution unit: owns the sample ring, scans it for queries, interpolates
// with a shared multiplier and the serial divider, and holds the response
// register.
// ----------------------------------------------------------------------------
module tsri_back #(
   parameter int RING_DEPTH = tsri_pkg::RING_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  tsri_pkg::cmd_type     q_data,
   output logic                  q_pop,
   output tsri_pkg::div_req_type div_req,
   input  tsri_pkg::div_sts_type div_sts,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tsri_pkg::rsp_type     rsp_data
);
   import tsri_pkg::*;

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(RING_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RING_DEPTH);
   localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(RING_DEPTH - 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SCAN = 4'd1;
   localparam logic [3:0] S_PRED = 4'd2;
   localparam logic [3:0] S_PDAT = 4'd3;
   localparam logic [3:0] S_MAG  = 4'd4;
   localparam logic [3:0] S_MUL0 = 4'd5;
   localparam logic [3:0] S_MUL1 = 4'd6;
   localparam logic [3:0] S_ADD  = 4'd7;
   localparam logic [3:0] S_CHK  = 4'd8;
   localparam logic [3:0] S_DIV  = 4'd9;
   localparam logic [3:0] S_SUM  = 4'd10;
   localparam logic [3:0] S_OUT  = 4'd11;

   typedef struct packed {
      logic [TIME_W-1:0]  stamp;
      logic [ANGLE_W-1:0] angle;
   } entry_type;

   entry_type mem [RING_DEPTH];
   entry_type rd_data_ff;
   logic      rd_ok_ff;

   logic [3:0]          state_ff, state_in;
   logic [PTR_W-1:0]    wp_ff, wp_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [PTR_W-1:0]    scan_addr_ff, scan_addr_in;
   logic [CNT_W-1:0]    iss_cnt_ff, iss_cnt_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic                cmp_last_ff, cmp_last_in;
   logic [PTR_W-1:0]    cmp_addr_ff, cmp_addr_in;
   logic [PTR_W-1:0]    j_addr_ff, j_addr_in;
   logic [TIME_W-1:0]   query_ff, query_in;
   logic [TIME_W-1:0]   tj_ff, tj_in;
   logic [ANGLE_W-1:0]  aj_ff, aj_in;
   logic [ANGLE_W-1:0]  ap_ff, ap_in;
   logic [DIFF_A_W-1:0] da_ff, da_in;
   logic [DIFF_T_W-1:0] dt_ff, dt_in;
   logic [DIFF_T_W-1:0] dq_ff, dq_in;
   logic [ANGLE_W-1:0]  ma_ff, ma_in;
   logic [TIME_W-1:0]   mt_ff, mt_in;
   logic [TIME_W-1:0]   mq_ff, mq_in;
   logic                neg_ff, neg_in;
   logic [PART_W-1:0]   p0_ff, p0_in;
   logic [PART_W-1:0]   p1_ff, p1_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [ANGLE_W-1:0]  res_angle_ff, res_angle_in;
   logic                res_found_ff, res_found_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic [PTR_W-1:0]    rd_addr;
   logic [PTR_W-1:0]    pred_addr;
   logic [TIME_W-1:0]   rd_time;
   logic [ANGLE_W-1:0]  rd_angle;
   logic                store_now;
   logic                issuing;
   logic [DIFF_A_W-1:0] da_neg;
   logic [DIFF_T_W-1:0] dt_neg;
   logic [DIFF_T_W-1:0] dq_neg;
   logic [HALF_W-1:0]   mul_b;
   logic [PART_W-1:0]   mul_out;
   logic [QUOT_W-1:0]   prod_hi;
   logic                big;
   logic [SUM_W-1:0]    ap_ext;
   logic [SUM_W-1:0]    q_ext;
   logic [SUM_W-1:0]    sum;
   logic                sum_fits;
   logic                out_free;

   // slots at or beyond the fill count have never been written and read as zero
   assign rd_time   = rd_ok_ff ? rd_data_ff.stamp : '0;
   assign rd_angle  = rd_ok_ff ? rd_data_ff.angle : '0;
   assign pred_addr = (j_addr_ff == '0) ? LAST_PTR : j_addr_ff - 1'b1;
   assign rd_addr   = (state_ff == S_PRED) ? pred_addr : scan_addr_ff;

   assign q_pop     = q_valid && (state_ff == S_IDLE);
   assign store_now = q_pop && (q_data.op == OP_STORE);
   assign issuing   = (iss_cnt_ff != DEPTH_CNT);

   assign da_neg  = -da_ff;
   assign dt_neg  = -dt_ff;
   assign dq_neg  = -dq_ff;
   assign mul_b   = (state_ff == S_MUL0) ? mq_ff[HALF_W-1:0] : mq_ff[TIME_W-1:HALF_W];
   assign mul_out = PART_W'(ma_ff) * PART_W'(mul_b);
   assign prod_hi = prod_ff[PROD_W-1:PROD_W-QUOT_W];
   assign big     = ({{(TIME_W-QUOT_W){1'b0}}, prod_hi} >= mt_ff);

   assign ap_ext   = {{(SUM_W-ANGLE_W){ap_ff[ANGLE_W-1]}}, ap_ff};
   assign q_ext    = {2'b00, div_sts.quotient};
   assign sum      = neg_ff ? ap_ext - q_ext : ap_ext + q_ext;
   assign sum_fits = (sum[SUM_W-1:ANGLE_W-1] == '0) || (sum[SUM_W-1:ANGLE_W-1] == '1);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign div_req.start    = (state_ff == S_CHK) && !big;
   assign div_req.rem_init = TIME_W'(prod_hi);
   assign div_req.dividend = prod_ff[QUOT_W-1:0];
   assign div_req.divisor  = mt_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      scan_addr_in = scan_addr_ff;
      iss_cnt_in   = iss_cnt_ff;
      cmp_vld_in   = 1'b0;
      cmp_last_in  = cmp_last_ff;
      cmp_addr_in  = cmp_addr_ff;
      j_addr_in    = j_addr_ff;
      query_in     = query_ff;
      tj_in        = tj_ff;
      aj_in        = aj_ff;
      ap_in        = ap_ff;
      da_in        = da_ff;
      dt_in        = dt_ff;
      dq_in        = dq_ff;
      ma_in        = ma_ff;
      mt_in        = mt_ff;
      mq_in        = mq_ff;
      neg_in       = neg_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      prod_in      = prod_ff;
      res_angle_in = res_angle_ff;
      res_found_in = res_found_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (store_now) begin
               wp_in = (wp_ff == LAST_PTR) ? '0 : wp_ff + 1'b1;
               if (fill_ff != DEPTH_CNT) begin
                  fill_in = fill_ff + 1'b1;
               end
            end else if (q_pop) begin
               // start at the oldest slot
               query_in     = q_data.stamp;
               scan_addr_in = wp_ff;
               iss_cnt_in   = '0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            if (issuing) begin
               scan_addr_in = (scan_addr_ff == LAST_PTR) ? '0 : scan_addr_ff + 1'b1;
               iss_cnt_in   = iss_cnt_ff + 1'b1;
               cmp_vld_in   = 1'b1;
               cmp_addr_in  = scan_addr_ff;
               cmp_last_in  = (iss_cnt_ff == LAST_CNT);
            end
            if (cmp_vld_ff && (rd_time > query_ff)) begin
               j_addr_in  = cmp_addr_ff;
               tj_in      = rd_time;
               aj_in      = rd_angle;
               cmp_vld_in = 1'b0;
               state_in   = S_PRED;
            end else if (cmp_vld_ff && cmp_last_ff) begin
               res_angle_in = '0;
               res_found_in = 1'b0;
               cmp_vld_in   = 1'b0;
               state_in     = S_OUT;
            end
         end
         S_PRED: begin
            state_in = S_PDAT;
         end
         S_PDAT: begin
            ap_in    = rd_angle;
            da_in    = {aj_ff[ANGLE_W-1], aj_ff} - {rd_angle[ANGLE_W-1], rd_angle};
            dt_in    = {1'b0, tj_ff} - {1'b0, rd_time};
            dq_in    = {1'b0, query_ff} - {1'b0, rd_time};
            state_in = S_MAG;
         end
         S_MAG: begin
            ma_in  = da_ff[DIFF_A_W-1] ? da_neg[ANGLE_W-1:0] : da_ff[ANGLE_W-1:0];
            mt_in  = dt_ff[DIFF_T_W-1] ? dt_neg[TIME_W-1:0] : dt_ff[TIME_W-1:0];
            mq_in  = dq_ff[DIFF_T_W-1] ? dq_neg[TIME_W-1:0] : dq_ff[TIME_W-1:0];
            neg_in = da_ff[DIFF_A_W-1] ^ dt_ff[DIFF_T_W-1] ^ dq_ff[DIFF_T_W-1];
            res_found_in = 1'b1;
            if (dt_ff == '0) begin
               // equal timestamps: return the predecessor as it is
               res_angle_in = ap_ff;
               state_in     = S_OUT;
            end else begin
               state_in = S_MUL0;
            end
         end
         S_MUL0: begin
            p0_in    = mul_out;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            p1_in    = mul_out;
            state_in = S_ADD;
         end
         S_ADD: begin
            prod_in  = PROD_W'(p0_ff) + {p1_ff, {HALF_W{1'b0}}};
            state_in = S_CHK;
         end
         S_CHK: begin
            if (big) begin
               res_angle_in = neg_ff ? ANGLE_MIN : ANGLE_MAX;
               state_in     = S_OUT;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!div_sts.busy) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            if (sum_fits) begin
               res_angle_in = sum[ANGLE_W-1:0];
            end else begin
               res_angle_in = sum[SUM_W-1] ? ANGLE_MIN : ANGLE_MAX;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.result_angle = res_angle_ff;
               rsp_data_in.result_time  = res_found_ff ? query_ff : '0;
               rsp_data_in.found        = res_found_ff;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ring storage
   always_ff @(posedge clock) begin
      if (store_now) begin
         mem[wp_ff] <= {q_data.stamp, q_data.angle};
      end
      rd_data_ff <= mem[rd_addr];
      rd_ok_ff   <= (CNT_W'(rd_addr) < fill_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         iss_cnt_ff   <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         iss_cnt_ff   <= iss_cnt_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_addr_ff <= scan_addr_in;
      cmp_last_ff  <= cmp_last_in;
      cmp_addr_ff  <= cmp_addr_in;
      j_addr_ff    <= j_addr_in;
      query_ff     <= query_in;
      tj_ff        <= tj_in;
      aj_ff        <= aj_in;
      ap_ff        <= ap_in;
      da_ff        <= da_in;
      dt_ff        <= dt_in;
      dq_ff        <= dq_in;
      ma_ff        <= ma_in;
      mt_ff        <= mt_in;
      mq_ff        <= mq_in;
      neg_ff       <= neg_in;
      p0_ff        <= p0_in;
      p1_ff        <= p1_in;
      prod_ff      <= prod_in;
      res_angle_ff <= res_angle_in;
      res_found_ff <= res_found_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

// ----- src/timestamped_ring_interpolator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_ring_interpolator
// Ring of timestamped angle samples with linear interpolation at a query time.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one beat per item: kind 0 stores (timestamp, angle) at the
//   write pointer and gives no response; kind 1 queries the angle at the
//   given time and gives exactly one rsp_* beat, in request order.
//   A beat moves on a rising edge with valid high and stall low.
//   Requests pass an input register and a two-entry command queue, so the
//   block takes further beats while the execution unit is busy or while a
//   finished response waits in the output register.
//   A store is written in the execution unit's idle state. A query first
//   scans the ring, one slot per cycle through the single memory read port;
//   then the 40-step serial divider dominates.
//   Reset empties the ring (all slots read as time zero, angle zero) and the
//   queue at once; no clearing pass is needed.
//   While rsp_stall is high the response holds; the queue keeps filling until
//   full, then req_stall rises.
// ----------------------------------------------------------------------------
module timestamped_ring_interpolator #(
   parameter int RING_DEPTH = tsri_pkg::RING_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tsri_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tsri_pkg::rsp_type rsp_data
);
   import tsri_pkg::*;

   logic        q_full;
   logic        q_push;
   cmd_type     q_push_data;
   logic        q_valid;
   logic        q_pop;
   cmd_type     q_pop_data;
   div_req_type div_req;
   div_sts_type div_sts;

   tsri_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   tsri_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_pop_data)
   );

   tsri_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_sts (div_sts)
   );

   tsri_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_pop_data),
      .q_pop     (q_pop),
      .div_req   (div_req),
      .div_sts   (div_sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- src/tsri_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsri_checker
// Port-level checks of the timestamped ring interpolator.
// ----------------------------------------------------------------------------
module tsri_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input tsri_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input tsri_pkg::rsp_type rsp_data
);
   import tsri_pkg::*;

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // a miss reports zero angle and zero time
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.result_angle == '0 &&
                                       rsp_data.result_time == '0)
      else $error("miss response carries data");

   // reset empties the output register
   a_rst_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // reset empties the input register
   a_rst_req: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("request stalled after reset");

endmodule

bind timestamped_ring_interpolator tsri_checker u_checker (.*);

// ----- dv/timestamped_ring_interpolator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_ring_interpolator_tb
// Self-checking bench for the timestamped ring interpolator.
// A directed table walks the empty ring, predecessor wrap, equal stamps,
// extrapolation and both saturation limits. Random sensor-like traffic then
// follows, mixed with noise and repeated stamps. Expected responses come from
// a local copy of the ring or the table row; each is checked field by field.
// ----------------------------------------------------------------------------
module timestamped_ring_interpolator_tb;
   import tsri_pkg::*;

   localparam int DEPTH        = RING_DEPTH_DEF;
   localparam int RANDOM_ITEMS = 1100;
   localparam int QUIET_TAIL   = 150;
   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 150;

   localparam logic [TIME_W-1:0] TIME_MAX     = '1;
   localparam longint            ANGLE_TOP    = 64'sh7FFF_FFFF;
   localparam longint            ANGLE_BOTTOM = -64'sh8000_0000;

   typedef struct {
      req_type     beat;
      int unsigned reps;
      bit          typed;
      rsp_type     want;
   } step_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // local copy of the ring
   logic signed [ANGLE_W-1:0] ring_angle [DEPTH];
   logic [TIME_W-1:0]         ring_time  [DEPTH];
   int unsigned               ring_head;
   rsp_type                   expected_readings [$];

   int unsigned error_count = 0;
   int unsigned stores_done = 0;
   int unsigned queries_done = 0;
   int unsigned hits_seen = 0;
   int unsigned idle_odds = 0;
   int unsigned stall_odds = 0;
   int unsigned stall_left = 0;
   int unsigned idle_cycles = 0;

   timestamped_ring_interpolator #(.RING_DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      error_count++;
      $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
   endtask

   // Linear blend between the hit slot and its ring predecessor.
   function automatic logic signed [ANGLE_W-1:0] blend(input int unsigned newer,
                                                      input int unsigned older,
                                                      input logic [TIME_W-1:0] when);
      longint       base, d_ang, d_t, d_q, sum;
      logic [127:0] m_ang, m_t, m_q, quot;
      bit           flip;
      base  = longint'(ring_angle[older]);
      d_ang = longint'(ring_angle[newer]) - base;
      d_t   = longint'({16'd0, ring_time[newer]}) - longint'({16'd0, ring_time[older]});
      d_q   = longint'({16'd0, when}) - longint'({16'd0, ring_time[older]});
      // equal stamps: no division, hold the predecessor
      if (d_t == 0) begin
         return ring_angle[older];
      end
      flip  = ((d_ang < 0) != (d_q < 0)) != (d_t < 0);
      m_ang = 128'((d_ang < 0) ? -d_ang : d_ang);
      m_t   = 128'((d_t < 0) ? -d_t : d_t);
      m_q   = 128'((d_q < 0) ? -d_q : d_q);
      quot  = (m_ang * m_q) / m_t;
      if (quot >= (128'd1 << QUOT_W)) begin
         return flip ? ANGLE_MIN : ANGLE_MAX;
      end
      sum = flip ? base - longint'(quot[63:0]) : base + longint'(quot[63:0]);
      if (sum > ANGLE_TOP) begin
         sum = ANGLE_TOP;
      end
      if (sum < ANGLE_BOTTOM) begin
         sum = ANGLE_BOTTOM;
      end
      return sum[ANGLE_W-1:0];
   endfunction

   // Scan oldest to newest for the first stamp later than the query time.
   function automatic rsp_type angle_at_time(input logic [TIME_W-1:0] when);
      rsp_type     reading;
      int unsigned k, slot;
      reading = '0;
      for (k = 0; k < DEPTH; k++) begin
         slot = (ring_head + k) % DEPTH;
         if (ring_time[slot] > when) begin
            reading.result_angle = blend(slot, (slot + DEPTH - 1) % DEPTH, when);
            reading.result_time  = when;
            reading.found        = 1'b1;
            return reading;
         end
      end
      return reading;
   endfunction

   function automatic step_row_type make_row(input logic kind,
                                             input logic [TIME_W-1:0] stamp,
                                             input logic [ANGLE_W-1:0] ang,
                                             input int unsigned reps = 1,
                                             input bit typed = 0,
                                             input logic [ANGLE_W-1:0] w_ang = '0,
                                             input logic [TIME_W-1:0] w_time = '0,
                                             input logic w_found = 1'b0);
      step_row_type row;
      row.beat.kind         = kind;
      row.beat.timestamp    = stamp;
      row.beat.angle        = ang;
      row.reps              = reps;
      row.typed             = typed;
      row.want.result_angle = w_ang;
      row.want.result_time  = w_time;
      row.want.found        = w_found;
      return row;
   endfunction

   task automatic take_beat(input req_type beat, input bit typed, input rsp_type want);
      rsp_type reading;
      if (beat.kind == OP_STORE) begin
         ring_angle[ring_head] = beat.angle;
         ring_time[ring_head]  = beat.timestamp;
         ring_head             = (ring_head + 1) % DEPTH;
         stores_done++;
      end else begin
         reading = typed ? want : angle_at_time(beat.timestamp);
         expected_readings.push_back(reading);
         queries_done++;
         if (reading.found) begin
            hits_seen++;
         end
      end
   endtask

   task automatic send_beat(input req_type beat, input bit typed, input rsp_type want);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_data  <= beat;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      take_beat(beat, typed, want);
   endtask

   // response checker and stall generator
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               flag_mismatch("response with no query waiting", 64'(rsp_data), '0);
            end else begin
               want = expected_readings.pop_front();
               if (rsp_data.result_angle !== want.result_angle) begin
                  flag_mismatch("result_angle", 64'(rsp_data.result_angle),
                                64'(want.result_angle));
               end
               if (rsp_data.result_time !== want.result_time) begin
                  flag_mismatch("result_time", 64'(rsp_data.result_time),
                                64'(want.result_time));
               end
               if (rsp_data.found !== want.found) begin
                  flag_mismatch("found", 64'(rsp_data.found), 64'(want.found));
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
         end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            stall_left = $urandom_range(1, 18);
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   // watchdog: too long without a beat on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("timestamped_ring_interpolator_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      step_row_type              plan [$];
      req_type                   beat;
      rsp_type                   none;
      logic [TIME_W-1:0]         now_us;
      logic signed [ANGLE_W-1:0] theta;
      int                        delta;
      int unsigned               issued, burst, style, rep, b, k;
      none = '0;
      for (k = 0; k < DEPTH; k++) begin
         ring_angle[k] = '0;
         ring_time[k]  = '0;
      end
      ring_head = 0;

      // empty ring: every slot stamped zero, so nothing is later
      plan.push_back(make_row(OP_QUERY, 0, 0, 1, 1));
      plan.push_back(make_row(OP_QUERY, TIME_MAX, '1, 1, 1));
      plan.push_back(make_row(OP_STORE, 100, 1000));
      // halfway between the never-written last slot and slot zero
      plan.push_back(make_row(OP_QUERY, 50, 0, 1, 1, 500, 50, 1'b1));
      plan.push_back(make_row(OP_STORE, 200, -32'sd1000));
      plan.push_back(make_row(OP_QUERY, 150, 0));
      plan.push_back(make_row(OP_QUERY, 100, 0));
      plan.push_back(make_row(OP_QUERY, 250, 0, 1, 1));
      plan.push_back(make_row(OP_STORE, TIME_MAX, ANGLE_MAX));
      plan.push_back(make_row(OP_QUERY, 300, 0));
      // fill the whole ring with one stamp: oldest hit meets an equal newest
      plan.push_back(make_row(OP_STORE, 1000, ANGLE_MIN, DEPTH));
      plan.push_back(make_row(OP_QUERY, 500, 0, 1, 1, ANGLE_MIN, 500, 1'b1));
      plan.push_back(make_row(OP_QUERY, 1000, 0, 1, 1));
      // newest just below the oldest: steep slope, quotient overflows high
      plan.push_back(make_row(OP_STORE, 999, ANGLE_MAX));
      plan.push_back(make_row(OP_QUERY, 0, 0, 1, 1, ANGLE_MAX, 0, 1'b1));
      plan.push_back(make_row(OP_QUERY, 998, 0));
      // newest just above the oldest: stamps out of order, overflows low
      plan.push_back(make_row(OP_STORE, 1001, ANGLE_MAX));
      plan.push_back(make_row(OP_QUERY, 0, 0, 1, 1, ANGLE_MIN, 0, 1'b1));
      plan.push_back(make_row(OP_STORE, 0, 0));
      plan.push_back(make_row(OP_QUERY, 999, '1));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      idle_odds  = 4;
      stall_odds = 8;
      foreach (plan[r]) begin
         for (rep = 0; rep < plan[r].reps; rep++) begin
            send_beat(plan[r].beat, plan[r].typed, plan[r].want);
         end
      end

      issued = 0;
      now_us = 48'd5000;
      theta  = '0;
      while (issued < RANDOM_ITEMS) begin
         if (issued >= RANDOM_ITEMS - QUIET_TAIL) begin
            idle_odds  = 0;
            stall_odds = 0;
         end else begin
            case ($urandom_range(0, 2))
               0: idle_odds = 0;
               1: idle_odds = 3;
               default: idle_odds = 12;
            endcase
            case ($urandom_range(0, 2))
               0: stall_odds = 0;
               1: stall_odds = 4;
               default: stall_odds = 16;
            endcase
         end
         burst = $urandom_range(4, 40);
         style = $urandom_range(0, 9);
         // jump the sensor clock, sometimes close enough to the top to wrap
         if (style == 9) begin
            now_us = $urandom_range(0, 1) ? TIME_MAX - $urandom_range(0, 60000)
                                          : TIME_W'({$urandom, $urandom});
         end
         for (b = 0; b < burst && issued < RANDOM_ITEMS; b++) begin
            beat       = '0;
            beat.angle = $urandom;
            if (style <= 5 || style == 9) begin
               // sensor-like: rising stamps, slowly moving angle, delayed queries
               if ($urandom_range(0, 9) < 6) begin
                  now_us = now_us + $urandom_range(1, 5000);
                  if ($urandom_range(0, 19) == 0) begin
                     theta = $urandom;
                  end else begin
                     delta = int'($urandom_range(0, 1 << 20)) - (1 << 19);
                     theta = theta + delta;
                  end
                  beat.kind      = OP_STORE;
                  beat.timestamp = now_us;
                  beat.angle     = theta;
               end else begin
                  beat.kind      = OP_QUERY;
                  beat.timestamp = ($urandom_range(0, 7) == 0)
                                   ? now_us + $urandom_range(0, 200)
                                   : now_us - $urandom_range(0, 40000);
               end
            end else if (style <= 7) begin
               beat.kind      = $urandom_range(0, 1) ? OP_QUERY : OP_STORE;
               beat.timestamp = TIME_W'({$urandom, $urandom});
            end else begin
               // repeated stamps around the current time
               if ($urandom_range(0, 1)) begin
                  beat.kind      = OP_STORE;
                  beat.timestamp = now_us;
               end else begin
                  beat.kind      = OP_QUERY;
                  beat.timestamp = now_us - $urandom_range(0, 3000);
               end
            end
            send_beat(beat, 1'b0, none);
            issued++;
         end
      end
      req_valid <= 1'b0;

      while (expected_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d stored samples and %0d queries, %0d of them with a later sample,",
               stores_done, queries_done, hits_seen);
      $display("with random gaps on the request side and stalls on the response side");
      if (error_count == 0) begin
         $display("timestamped_ring_interpolator_tb: done, clean");
      end else begin
         $display("timestamped_ring_interpolator_tb: done, errors");
      end
      $finish;
   end

endmodule
